// ===== rtl/core/adc_scan_sequencer_vref_cal_macros.svh =====
// ---------------------------------------------------------------------------
// ADC scan sequencer assertion macros
// Shorthand for the concurrent checks used inside the sequencer modules.
// Each macro expects signals named clk and rst_n in the calling scope.
// ---------------------------------------------------------------------------
`ifndef ADC_SCAN_SEQUENCER_VREF_CAL_MACROS_SVH
`define ADC_SCAN_SEQUENCER_VREF_CAL_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ADCSEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define ADCSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/adcseq_pkg.sv =====
// ---------------------------------------------------------------------------
// ADC scan sequencer package
// Field widths, request and register codes, reset values and the types
// shared by the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package adcseq_pkg;

  localparam int MAX_SLOTS_DEF = 4;

  localparam int REQ_W      = 2;
  localparam int RAW_W      = 10;
  localparam int CH_W       = 5;
  localparam int STAT_W     = 2;
  localparam int MV_W       = 16;
  localparam int VBG_W      = 12;
  localparam int LEN_W      = 3;
  localparam int CAL_SHIFT  = 10;
  localparam int VDD_W      = VBG_W + CAL_SHIFT;
  localparam int PROD_W     = VDD_W + RAW_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int NUM_CH_REGS = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_POLL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DONE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  // Read status codes
  localparam logic [STAT_W-1:0] RD_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] RD_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] RD_MISS  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_CH0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VBG_MV  = 3'd5;

  // Register reset values
  localparam logic [LEN_W-1:0] SEQ_LEN_RST = 3'd3;
  localparam logic [VBG_W-1:0] VBG_MV_RST  = 12'd815;

  function automatic logic [CH_W-1:0] chan_rst(input int slot);
    logic [CH_W-1:0] ch;
    case (slot)
      0:       ch = 5'd4;
      1:       ch = 5'd5;
      2:       ch = 5'd6;
      default: ch = 5'd0;
    endcase
    return ch;
  endfunction

  // Scan phase kept across items
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_VREF_WAIT,
    PH_CH_START,
    PH_CH_WAIT
  } phase_t;

  // Per-item sequencing
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_DIV,
    SQ_STORE,
    SQ_PUSH
  } seq_state_t;

  typedef struct packed {
    logic load;
    logic latch_raw;
    logic launch_vref;
    logic launch_ch;
    logic do_read;
    logic vdd_clear;
    logic div_start;
    logic mul_load;
    logic store;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             raw_zero;
    logic             len_zero;
    logic             div_done;
    logic             out_free;
  } dp_status_t;

  typedef struct packed {
    logic              start_conv;
    logic [CH_W-1:0]   conv_channel;
    logic              conv_is_vref;
    logic [STAT_W-1:0] read_status;
    logic [RAW_W-1:0]  read_raw;
    logic [MV_W-1:0]   read_mv;
    logic [VDD_W-1:0]  supply_mv;
  } result_t;

endpackage

// ===== rtl/core/adcseq_ifs.sv =====
// ---------------------------------------------------------------------------
// ADC scan sequencer channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ---------------------------------------------------------------------------
interface adcseq_in_if;
  logic                          valid;
  logic                          ready;
  logic [adcseq_pkg::REQ_W-1:0]  req_type;
  logic [adcseq_pkg::RAW_W-1:0]  conv_raw;
  logic [adcseq_pkg::CH_W-1:0]   query_channel;

  modport source (output valid, req_type, conv_raw, query_channel, input ready);
  modport sink   (input valid, req_type, conv_raw, query_channel, output ready);
endinterface

interface adcseq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          start_conv;
  logic [adcseq_pkg::CH_W-1:0]   conv_channel;
  logic                          conv_is_vref;
  logic [adcseq_pkg::STAT_W-1:0] read_status;
  logic [adcseq_pkg::RAW_W-1:0]  read_raw;
  logic [adcseq_pkg::MV_W-1:0]   read_mv;
  logic [adcseq_pkg::VDD_W-1:0]  supply_mv;

  modport source (output valid, start_conv, conv_channel, conv_is_vref, read_status,
                  read_raw, read_mv, supply_mv, input ready);
  modport sink   (input valid, start_conv, conv_channel, conv_is_vref, read_status,
                  read_raw, read_mv, supply_mv, output ready);
endinterface

interface adcseq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [adcseq_pkg::CFG_IDX_W-1:0]  index;
  logic [adcseq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/adcseq_div.sv =====
// ---------------------------------------------------------------------------
// ADC scan sequencer calibration divider
// Restoring radix-2 divider, one quotient bit per cycle, for the supply
// calibration quotient. Divisor must be nonzero.
// ---------------------------------------------------------------------------
module adcseq_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [adcseq_pkg::VDD_W-1:0] dividend,
  input  logic [adcseq_pkg::RAW_W-1:0] divisor,
  output logic                         done,
  output logic [adcseq_pkg::VDD_W-1:0] quotient
);

  localparam int VDD_W = adcseq_pkg::VDD_W;
  localparam int RAW_W = adcseq_pkg::RAW_W;
  localparam int CNT_W = $clog2(VDD_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VDD_W-1:0] quo_r;
  logic [VDD_W-1:0] quo_nxt;
  logic [RAW_W-1:0] rem_r;
  logic [RAW_W-1:0] rem_nxt;
  logic [RAW_W-1:0] dsr_r;
  logic [RAW_W:0]   rem_sh;
  logic [RAW_W:0]   rem_sub;
  logic             ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[VDD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
    quo_nxt = {quo_r[VDD_W-2:0], ge};
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(VDD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/adcseq_ctrl.sv =====
// ---------------------------------------------------------------------------
// ADC scan sequencer controller
// Holds the scan phase and converter flags and sequences each item through
// decode, optional divide or store, and result transfer.
// ---------------------------------------------------------------------------
`include "adc_scan_sequencer_vref_cal_macros.svh"

module adcseq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  adcseq_pkg::dp_status_t sts,
  output adcseq_pkg::dp_cmd_t    cmd
);

  adcseq_pkg::seq_state_t state_r, state_nxt;
  adcseq_pkg::phase_t     phase_r, phase_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  // Next state and scan flags
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    case (state_r)
      adcseq_pkg::SQ_IDLE: begin
        if (in_valid) begin
          state_nxt = adcseq_pkg::SQ_EXEC;
        end
      end
      adcseq_pkg::SQ_EXEC: begin
        state_nxt = adcseq_pkg::SQ_PUSH;
        case (sts.req)
          adcseq_pkg::REQ_POLL: begin
            case (phase_r)
              adcseq_pkg::PH_IDLE: begin
                done_nxt  = 1'b0;
                busy_nxt  = 1'b1;
                phase_nxt = adcseq_pkg::PH_VREF_WAIT;
              end
              adcseq_pkg::PH_VREF_WAIT: begin
                if (done_r) begin
                  done_nxt  = 1'b0;
                  phase_nxt = adcseq_pkg::PH_CH_START;
                  if (!sts.raw_zero) begin
                    state_nxt = adcseq_pkg::SQ_DIV;
                  end
                end
              end
              adcseq_pkg::PH_CH_START: begin
                if (!busy_r && !sts.len_zero) begin
                  done_nxt  = 1'b0;
                  busy_nxt  = 1'b1;
                  phase_nxt = adcseq_pkg::PH_CH_WAIT;
                end
              end
              adcseq_pkg::PH_CH_WAIT: begin
                if (done_r) begin
                  done_nxt  = 1'b0;
                  phase_nxt = adcseq_pkg::PH_CH_START;
                  state_nxt = adcseq_pkg::SQ_STORE;
                end
              end
              default: ;
            endcase
          end
          adcseq_pkg::REQ_DONE: begin
            done_nxt = 1'b1;
            busy_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      adcseq_pkg::SQ_DIV: begin
        if (sts.div_done) begin
          state_nxt = adcseq_pkg::SQ_PUSH;
        end
      end
      adcseq_pkg::SQ_STORE: begin
        state_nxt = adcseq_pkg::SQ_PUSH;
      end
      adcseq_pkg::SQ_PUSH: begin
        if (sts.out_free) begin
          state_nxt = adcseq_pkg::SQ_IDLE;
        end
      end
      default: state_nxt = adcseq_pkg::SQ_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      adcseq_pkg::SQ_IDLE: cmd.load = in_valid;
      adcseq_pkg::SQ_EXEC: begin
        case (sts.req)
          adcseq_pkg::REQ_POLL: begin
            case (phase_r)
              adcseq_pkg::PH_IDLE: cmd.launch_vref = 1'b1;
              adcseq_pkg::PH_VREF_WAIT: begin
                if (done_r) begin
                  cmd.vdd_clear = sts.raw_zero;
                  cmd.div_start = !sts.raw_zero;
                end
              end
              adcseq_pkg::PH_CH_START: cmd.launch_ch = !busy_r && !sts.len_zero;
              adcseq_pkg::PH_CH_WAIT:  cmd.mul_load  = done_r;
              default: ;
            endcase
          end
          adcseq_pkg::REQ_DONE: cmd.latch_raw = 1'b1;
          adcseq_pkg::REQ_READ: cmd.do_read   = 1'b1;
          default: ;
        endcase
      end
      adcseq_pkg::SQ_STORE: cmd.store = 1'b1;
      adcseq_pkg::SQ_PUSH:  cmd.push  = sts.out_free;
      default: ;
    endcase
  end

  assign in_ready = (state_r == adcseq_pkg::SQ_IDLE);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adcseq_pkg::SQ_IDLE;
      phase_r <= adcseq_pkg::PH_IDLE;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  `ADCSEQ_ASSERT_SAME(a_busy_done_excl, 1'b1, !(busy_r && done_r), "busy and done both set")
  `ADCSEQ_ASSERT_SAME(a_div_in_cal, cmd.div_start, (phase_r == adcseq_pkg::PH_VREF_WAIT) && done_r, "divide outside calibration")
  `ADCSEQ_ASSERT_NEXT(a_exec_once, state_r == adcseq_pkg::SQ_EXEC, (state_r != adcseq_pkg::SQ_EXEC) && (state_r != adcseq_pkg::SQ_IDLE), "decode did not advance")

endmodule

// ===== rtl/core/adcseq_dp.sv =====
// ---------------------------------------------------------------------------
// ADC scan sequencer datapath
// Configuration registers, item registers, scan slot stores, calibration
// divider, millivolt scaling and the result output register.
// ---------------------------------------------------------------------------
`include "adc_scan_sequencer_vref_cal_macros.svh"

module adcseq_dp #(
  parameter int MAX_SLOTS = adcseq_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [adcseq_pkg::REQ_W-1:0]      in_req_type,
  input  logic [adcseq_pkg::RAW_W-1:0]      in_conv_raw,
  input  logic [adcseq_pkg::CH_W-1:0]       in_query_channel,
  input  logic                              cfg_valid,
  input  logic [adcseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adcseq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  adcseq_pkg::dp_cmd_t               cmd,
  output adcseq_pkg::dp_status_t            sts,
  output adcseq_pkg::result_t               out_item,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int REQ_W   = adcseq_pkg::REQ_W;
  localparam int RAW_W   = adcseq_pkg::RAW_W;
  localparam int CH_W    = adcseq_pkg::CH_W;
  localparam int MV_W    = adcseq_pkg::MV_W;
  localparam int VBG_W   = adcseq_pkg::VBG_W;
  localparam int LEN_W   = adcseq_pkg::LEN_W;
  localparam int VDD_W   = adcseq_pkg::VDD_W;
  localparam int PROD_W  = adcseq_pkg::PROD_W;
  localparam int SHIFT   = adcseq_pkg::CAL_SHIFT;
  localparam int IDX_W   = adcseq_pkg::CFG_IDX_W;
  localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W   = CNT_W + 1;
  localparam int LCMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Configuration
  logic [LEN_W-1:0]  seq_len_r;
  logic [CH_W-1:0]   chan_r [MAX_SLOTS];
  logic [VBG_W-1:0]  vbg_r;

  // Item and scan state
  logic [REQ_W-1:0]  req_r;
  logic [RAW_W-1:0]  raw_in_r;
  logic [CH_W-1:0]   qch_r;
  logic [RAW_W-1:0]  latest_raw_r;
  logic [VDD_W-1:0]  vdd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [RAW_W-1:0]  raw_st_r [MAX_SLOTS];
  logic [MV_W-1:0]   mv_st_r  [MAX_SLOTS];
  logic [PROD_W-1:0] prod_r;
  adcseq_pkg::result_t res_r;
  adcseq_pkg::result_t out_r;
  adcseq_pkg::result_t push_item;
  logic              out_valid_r;

  logic [CNT_W-1:0]  len;
  logic [LCMP_W-1:0] len_raw;
  logic [SLOT_W-1:0] slot_fix;
  logic [SLOT_W-1:0] slot_adv;
  logic [CMP_W-1:0]  slot_inc;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [MV_W-1:0]   mv_sat;
  logic              div_done;
  logic [VDD_W-1:0]  div_q;
  logic              out_launch;
  logic              out_read;

  // Clamp scan length to the slot count
  always_comb begin
    len_raw = (LCMP_W'(seq_len_r) > LCMP_W'(MAX_SLOTS)) ? LCMP_W'(MAX_SLOTS)
                                                          : LCMP_W'(seq_len_r);
    len     = CNT_W'(len_raw);
  end

  // Slot wrap for launch and advance
  always_comb begin
    slot_fix = (CMP_W'(slot_r) >= CMP_W'(len)) ? '0 : slot_r;
    slot_inc = CMP_W'(slot_r) + CMP_W'(1);
    slot_adv = (slot_inc >= CMP_W'(len)) ? '0 : SLOT_W'(slot_inc);
  end

  // Lowest matching active slot for a read
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < len) && (chan_r[i] == qch_r)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // Saturate scaled millivolts
  assign mv_sat = (|prod_r[PROD_W-1:SHIFT+MV_W]) ? '1 : prod_r[SHIFT+MV_W-1:SHIFT];

  // Stamp the current supply on the outgoing result
  always_comb begin
    push_item           = res_r;
    push_item.supply_mv = vdd_r;
  end

  adcseq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (VDD_W'(vbg_r) << SHIFT),
    .divisor  (latest_raw_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Configuration registers, scan state and slot stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r    <= adcseq_pkg::SEQ_LEN_RST;
      vbg_r        <= adcseq_pkg::VBG_MV_RST;
      latest_raw_r <= '0;
      vdd_r        <= '0;
      slot_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        chan_r[i]   <= adcseq_pkg::chan_rst(i);
        raw_st_r[i] <= '0;
        mv_st_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid && (cfg_index == adcseq_pkg::CFG_SEQ_LEN)) begin
        seq_len_r <= cfg_data[LEN_W-1:0];
      end
      if (cfg_valid && (cfg_index == adcseq_pkg::CFG_VBG_MV)) begin
        vbg_r <= cfg_data[VBG_W-1:0];
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (cfg_valid && (i < adcseq_pkg::NUM_CH_REGS) &&
            (cfg_index == IDX_W'(i) + adcseq_pkg::CFG_SEQ_CH0)) begin
          chan_r[i] <= cfg_data[CH_W-1:0];
        end
      end

      // Slot index: reset by a length write, else follow the scan
      if (cfg_valid && (cfg_index == adcseq_pkg::CFG_SEQ_LEN)) begin
        slot_r <= '0;
      end else if (cmd.launch_ch) begin
        slot_r <= slot_fix;
      end else if (cmd.store) begin
        slot_r <= slot_adv;
      end

      if (cmd.latch_raw) begin
        latest_raw_r <= raw_in_r;
      end

      if (cmd.vdd_clear) begin
        vdd_r <= '0;
      end else if (div_done) begin
        vdd_r <= div_q;
      end

      if (cmd.store) begin
        raw_st_r[slot_r] <= latest_raw_r;
        mv_st_r[slot_r]  <= mv_sat;
      end

      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture, product and result staging
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      raw_in_r <= in_conv_raw;
      qch_r    <= in_query_channel;
      res_r    <= '0;
    end else begin
      if (cmd.launch_vref) begin
        res_r.start_conv   <= 1'b1;
        res_r.conv_is_vref <= 1'b1;
      end
      if (cmd.launch_ch) begin
        res_r.start_conv   <= 1'b1;
        res_r.conv_channel <= chan_r[slot_fix];
      end
      if (cmd.do_read) begin
        res_r.read_status <= hit ? adcseq_pkg::RD_FOUND : adcseq_pkg::RD_MISS;
        res_r.read_raw    <= hit ? raw_st_r[hit_idx] : '0;
        res_r.read_mv     <= hit ? mv_st_r[hit_idx] : '0;
      end
    end
    if (cmd.mul_load) begin
      prod_r <= PROD_W'(vdd_r) * PROD_W'(latest_raw_r);
    end
    if (cmd.push) begin
      out_r <= push_item;
    end
  end

  // Status to the controller
  always_comb begin
    sts.req      = req_r;
    sts.raw_zero = (latest_raw_r == '0);
    sts.len_zero = (len == '0);
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  // Result flags for the checks below
  assign out_launch = out_valid_r && out_r.start_conv;
  assign out_read   = (out_r.read_status != adcseq_pkg::RD_NONE);

  `ADCSEQ_ASSERT_SAME(a_push_free, cmd.push, !out_valid_r || out_ready, "push over held result")
  `ADCSEQ_ASSERT_SAME(a_slot_range, 1'b1, CNT_W'(slot_r) < CNT_W'(MAX_SLOTS), "slot out of range")
  `ADCSEQ_ASSERT_SAME(a_launch_no_read, out_launch, !out_read, "launch and read in one result")

endmodule

// ===== rtl/core/adc_scan_sequencer_vref_cal.sv =====
// ---------------------------------------------------------------------------
// ADC scan sequencer with reference calibration
// Top level: controller, datapath and channel interfaces.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries poll ticks, conversion-complete items and channel reads;
//   out_ch returns exactly one result item per accepted request; cfg_ch
//   writes the scan length, the slot channels and the bandgap millivolts and
//   is always ready. Write registers only while no request is in flight.
// Sequencing:
//   A request is accepted only in idle; it is decoded and its result is then
//   transferred to the output register, and only then is the next request
//   taken. The poll that stores a scanned slot adds a step (registered
//   multiply, then store). The calibration poll runs the serial divider, one
//   quotient bit per cycle over 22 bits, before its result is transferred.
// Reset:
//   rst_n (synchronous) restores register defaults, clears the slot stores,
//   the supply value and the scan phase; the first poll launches the
//   reference conversion.
// Stall:
//   A finished result waits in the output register; one further request is
//   accepted and processed meanwhile, then held until out_ch is taken.
// ---------------------------------------------------------------------------
module adc_scan_sequencer_vref_cal #(
  parameter int MAX_SLOTS = adcseq_pkg::MAX_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  adcseq_in_if.sink     in_ch,
  adcseq_out_if.source  out_ch,
  adcseq_cfg_if.sink    cfg_ch
);

  adcseq_pkg::dp_cmd_t    cmd;
  adcseq_pkg::dp_status_t sts;
  adcseq_pkg::result_t    out_item;
  logic                   out_valid;
  logic                   in_ready;

  adcseq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  adcseq_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_ch.req_type),
    .in_conv_raw      (in_ch.conv_raw),
    .in_query_channel (in_ch.query_channel),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .cmd              (cmd),
    .sts              (sts),
    .out_item         (out_item),
    .out_valid        (out_valid),
    .out_ready        (out_ch.ready)
  );

  // Drive channel handshakes and result payload
  assign in_ch.ready         = in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid;
  assign out_ch.start_conv   = out_item.start_conv;
  assign out_ch.conv_channel = out_item.conv_channel;
  assign out_ch.conv_is_vref = out_item.conv_is_vref;
  assign out_ch.read_status  = out_item.read_status;
  assign out_ch.read_raw     = out_item.read_raw;
  assign out_ch.read_mv      = out_item.read_mv;
  assign out_ch.supply_mv    = out_item.supply_mv;

endmodule
